// ----- hdl/srlp_pkg.sv -----
`timescale 1ns / 1ps

package srlp_pkg;

	localparam int unsigned RATE_W  = 18;
	localparam int unsigned PITCH_W = 32;
	localparam int unsigned PROD_W  = 32;
	localparam int unsigned POS_W   = 5;
	localparam int unsigned IDX_W   = 7;
	localparam int unsigned FRAC_W  = 7;
	localparam int unsigned MAG_W   = 20;
	localparam int unsigned SLOPE_W = 7;
	localparam int unsigned CHR_W   = 12;
	localparam int unsigned CHR_LSB = 20;
	localparam int unsigned TAB_N   = 1 << IDX_W;

	localparam logic [13:0]      RATE_SCALE = 14'd11185;
	localparam logic [CHR_W-1:0] POS_BIAS   = CHR_W'(15);

	// Mantissa of log2 at each of the 128 segment starts, 20 fraction bits.
	localparam logic [MAG_W-1:0] MAG_TAB [TAB_N] = '{
		20'h00000, 20'h02dfc, 20'h05b9e, 20'h088e6, 20'h0b5d6, 20'h0e26f, 20'h10eb3, 20'h13aa2,
		20'h1663f, 20'h1918a, 20'h1bc84, 20'h1e72e, 20'h2118b, 20'h23b9a, 20'h2655d, 20'h28ed5,
		20'h2b803, 20'h2e0e8, 20'h30985, 20'h331db, 20'h359eb, 20'h381b6, 20'h3a93d, 20'h3d081,
		20'h3f782, 20'h41e42, 20'h444c1, 20'h46b01, 20'h49101, 20'h4b6c4, 20'h4dc49, 20'h50191,
		20'h5269e, 20'h54b6f, 20'h57006, 20'h59463, 20'h5b888, 20'h5dc74, 20'h60029, 20'h623a7,
		20'h646ee, 20'h66a00, 20'h68cdd, 20'h6af86, 20'h6d1fa, 20'h6f43c, 20'h7164b, 20'h73829,
		20'h759d4, 20'h77b4f, 20'h79c9a, 20'h7bdb5, 20'h7dea1, 20'h7ff5e, 20'h81fed, 20'h8404e,
		20'h86082, 20'h88089, 20'h8a064, 20'h8c014, 20'h8df98, 20'h8fef1, 20'h91e20, 20'h93d26,
		20'h95c01, 20'h97ab4, 20'h9993e, 20'h9b79f, 20'h9d5d9, 20'h9f3ec, 20'ha11d8, 20'ha2f9d,
		20'ha4d3c, 20'ha6ab5, 20'ha8808, 20'haa537, 20'hac241, 20'hadf26, 20'hafbe7, 20'hb1885,
		20'hb3500, 20'hb5157, 20'hb6d8c, 20'hb899f, 20'hba58f, 20'hbc15e, 20'hbdd0c, 20'hbf899,
		20'hc1404, 20'hc2f50, 20'hc4a7b, 20'hc6587, 20'hc8073, 20'hc9b3f, 20'hcb5ed, 20'hcd07c,
		20'hceaec, 20'hd053f, 20'hd1f73, 20'hd398a, 20'hd5384, 20'hd6d60, 20'hd8720, 20'hda0c3,
		20'hdba4a, 20'hdd3b4, 20'hded03, 20'he0636, 20'he1f4e, 20'he384a, 20'he512c, 20'he69f3,
		20'he829f, 20'he9b31, 20'heb3a9, 20'hecc08, 20'hee44c, 20'hefc78, 20'hf148a, 20'hf2c83,
		20'hf4463, 20'hf5c2a, 20'hf73da, 20'hf8b71, 20'hfa2f0, 20'hfba57, 20'hfd1a7, 20'hfe8df
	};

	// Slope of each segment, applied to the next seven bits.
	localparam logic [SLOPE_W-1:0] SLOPE_TAB [TAB_N] = '{
		7'h5c, 7'h5c, 7'h5b, 7'h5a, 7'h5a, 7'h59, 7'h58, 7'h58,
		7'h57, 7'h56, 7'h56, 7'h55, 7'h55, 7'h54, 7'h53, 7'h53,
		7'h52, 7'h52, 7'h51, 7'h51, 7'h50, 7'h50, 7'h4f, 7'h4f,
		7'h4e, 7'h4d, 7'h4d, 7'h4d, 7'h4c, 7'h4c, 7'h4b, 7'h4b,
		7'h4a, 7'h4a, 7'h49, 7'h49, 7'h48, 7'h48, 7'h47, 7'h47,
		7'h47, 7'h46, 7'h46, 7'h45, 7'h45, 7'h45, 7'h44, 7'h44,
		7'h43, 7'h43, 7'h43, 7'h42, 7'h42, 7'h42, 7'h41, 7'h41,
		7'h41, 7'h40, 7'h40, 7'h40, 7'h3f, 7'h3f, 7'h3f, 7'h3e,
		7'h3e, 7'h3e, 7'h3d, 7'h3d, 7'h3d, 7'h3c, 7'h3c, 7'h3c,
		7'h3b, 7'h3b, 7'h3b, 7'h3b, 7'h3a, 7'h3a, 7'h3a, 7'h39,
		7'h39, 7'h39, 7'h39, 7'h38, 7'h38, 7'h38, 7'h38, 7'h37,
		7'h37, 7'h37, 7'h37, 7'h36, 7'h36, 7'h36, 7'h36, 7'h35,
		7'h35, 7'h35, 7'h35, 7'h34, 7'h34, 7'h34, 7'h34, 7'h34,
		7'h33, 7'h33, 7'h33, 7'h33, 7'h32, 7'h32, 7'h32, 7'h32,
		7'h32, 7'h31, 7'h31, 7'h31, 7'h31, 7'h31, 7'h30, 7'h30,
		7'h30, 7'h30, 7'h30, 7'h2f, 7'h2f, 7'h2f, 7'h2f, 7'h2f
	};

endpackage

// ----- hdl/sample_rate_to_log_pitch_core.sv -----
`timescale 1ns / 1ps

// Sample rate to log2 pitch converter.
//
// Input: raise start with an 18-bit sample_rate (hertz). A beat is taken at
// every rising edge where start is high and busy is low. busy is always low,
// since every stage moves forward in every cycle, so a new rate can be given
// in every cycle.
// Output: pitch_word shows the 32-bit pitch (integer part in bits 31..20,
// wrapping modulo 2^32) for exactly one cycle while done is high. A rate of
// zero gives a pitch of zero.
// Throughput: one beat per cycle. A beat shows up on done once it has passed
// all five stages: the rate multiply, the leading-one search, the
// normalizing shift, the table lookups with the slope multiply, and the
// final sum.
// Reset: arst_n clears the valid bits of all stages at once, so nothing in
// flight survives reset; data registers are not reset.
// The receiver cannot stall: done is a strobe and each result must be taken
// in the cycle it is shown.

module sample_rate_to_log_pitch_core
	import srlp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [RATE_W-1:0]  sample_rate,
	output logic               done,
	output logic [PITCH_W-1:0] pitch_word
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [PROD_W-1:0]  prod_s1, prod_s2;
	logic [POS_W-1:0]   pos_s2, pos_s3;
	logic               zero_s2, zero_s3, zero_s4;
	logic [IDX_W-1:0]   idx_s3;
	logic [FRAC_W-1:0]  frac_s3;
	logic [CHR_W-1:0]   chr_s4;
	logic [MAG_W-1:0]   mag_s4;
	logic [13:0]        lin_s4;
	logic [PITCH_W-1:0] pitch_s5;

	logic [POS_W-1:0]  lead_pos;
	logic [PROD_W-1:0] norm;

	// The pipeline never holds, so nothing ever needs to wait at the input.
	assign busy = 1'b0;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Leading-one position of the scaled rate. The product is at least 11185
	// when nonzero, so the position is never below 13.
	always_comb begin
		lead_pos = '0;
		for (int i = 0; i < PROD_W; i++) begin
			if (prod_s1[i]) begin
				lead_pos = POS_W'(i);
			end
		end
	end

	// Shift the leading one up to bit 31.
	assign norm = prod_s2 << (POS_W'(PROD_W - 1) - pos_s2);

	always_ff @(posedge clk) begin
		// Stage 1: scale the rate. An 18-bit rate times 11185 fits in 32 bits.
		prod_s1 <= PROD_W'(sample_rate) * PROD_W'(RATE_SCALE);

		// Stage 2: leading-one search.
		prod_s2 <= prod_s1;
		pos_s2  <= lead_pos;
		zero_s2 <= (prod_s1 == '0);

		// Stage 3: normalize and split into table index and fraction.
		idx_s3  <= norm[30 -: IDX_W];
		frac_s3 <= norm[30 - IDX_W -: FRAC_W];
		pos_s3  <= pos_s2;
		zero_s3 <= zero_s2;

		// Stage 4: table lookups, slope times fraction, and the characteristic,
		// which wraps when the position is below 15.
		mag_s4  <= MAG_TAB[idx_s3];
		lin_s4  <= 14'(frac_s3) * 14'(SLOPE_TAB[idx_s3]);
		chr_s4  <= CHR_W'(pos_s3) - POS_BIAS;
		zero_s4 <= zero_s3;

		// Stage 5: final sum, modulo 2^32.
		if (zero_s4) begin
			pitch_s5 <= '0;
		end else begin
			pitch_s5 <= {chr_s4, {CHR_LSB{1'b0}}} + PITCH_W'(mag_s4) + PITCH_W'(lin_s4);
		end
	end

	assign done       = v_s5;
	assign pitch_word = pitch_s5;

endmodule

// ----- hdl/srlp_checker.sv -----
`timescale 1ns / 1ps

module srlp_checker
	import srlp_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [RATE_W-1:0]  sample_rate,
	input logic               done,
	input logic [PITCH_W-1:0] pitch_word
);

	// Every accepted beat raises done once it has passed through the pipeline.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("accepted beat did not produce a result after five cycles");

	// No result appears without a matching earlier beat.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5))
		else $error("result strobe without a matching input beat");

	// A zero rate gives a zero pitch.
	a_zero_rate: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (sample_rate == '0)) |-> ##5 (pitch_word == '0))
		else $error("zero rate did not give a zero pitch");

	// The converter never holds off the sender.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind sample_rate_to_log_pitch_core srlp_checker u_srlp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.sample_rate (sample_rate),
	.done        (done),
	.pitch_word  (pitch_word)
);

// ----- bench/tb_sample_rate_to_log_pitch_core.sv -----
`timescale 1ns / 1ps

module tb_sample_rate_to_log_pitch_core;
	import srlp_pkg::*;

	// Segment tables of the piecewise-linear log2, kept apart from the package
	// so that a wrong entry in the RTL tables shows up as a mismatch.
	localparam logic [19:0] SEG_BASE [128] = '{
		20'h00000, 20'h02dfc, 20'h05b9e, 20'h088e6, 20'h0b5d6, 20'h0e26f, 20'h10eb3, 20'h13aa2,
		20'h1663f, 20'h1918a, 20'h1bc84, 20'h1e72e, 20'h2118b, 20'h23b9a, 20'h2655d, 20'h28ed5,
		20'h2b803, 20'h2e0e8, 20'h30985, 20'h331db, 20'h359eb, 20'h381b6, 20'h3a93d, 20'h3d081,
		20'h3f782, 20'h41e42, 20'h444c1, 20'h46b01, 20'h49101, 20'h4b6c4, 20'h4dc49, 20'h50191,
		20'h5269e, 20'h54b6f, 20'h57006, 20'h59463, 20'h5b888, 20'h5dc74, 20'h60029, 20'h623a7,
		20'h646ee, 20'h66a00, 20'h68cdd, 20'h6af86, 20'h6d1fa, 20'h6f43c, 20'h7164b, 20'h73829,
		20'h759d4, 20'h77b4f, 20'h79c9a, 20'h7bdb5, 20'h7dea1, 20'h7ff5e, 20'h81fed, 20'h8404e,
		20'h86082, 20'h88089, 20'h8a064, 20'h8c014, 20'h8df98, 20'h8fef1, 20'h91e20, 20'h93d26,
		20'h95c01, 20'h97ab4, 20'h9993e, 20'h9b79f, 20'h9d5d9, 20'h9f3ec, 20'ha11d8, 20'ha2f9d,
		20'ha4d3c, 20'ha6ab5, 20'ha8808, 20'haa537, 20'hac241, 20'hadf26, 20'hafbe7, 20'hb1885,
		20'hb3500, 20'hb5157, 20'hb6d8c, 20'hb899f, 20'hba58f, 20'hbc15e, 20'hbdd0c, 20'hbf899,
		20'hc1404, 20'hc2f50, 20'hc4a7b, 20'hc6587, 20'hc8073, 20'hc9b3f, 20'hcb5ed, 20'hcd07c,
		20'hceaec, 20'hd053f, 20'hd1f73, 20'hd398a, 20'hd5384, 20'hd6d60, 20'hd8720, 20'hda0c3,
		20'hdba4a, 20'hdd3b4, 20'hded03, 20'he0636, 20'he1f4e, 20'he384a, 20'he512c, 20'he69f3,
		20'he829f, 20'he9b31, 20'heb3a9, 20'hecc08, 20'hee44c, 20'hefc78, 20'hf148a, 20'hf2c83,
		20'hf4463, 20'hf5c2a, 20'hf73da, 20'hf8b71, 20'hfa2f0, 20'hfba57, 20'hfd1a7, 20'hfe8df
	};

	localparam logic [6:0] SEG_SLOPE [128] = '{
		7'h5c, 7'h5c, 7'h5b, 7'h5a, 7'h5a, 7'h59, 7'h58, 7'h58,
		7'h57, 7'h56, 7'h56, 7'h55, 7'h55, 7'h54, 7'h53, 7'h53,
		7'h52, 7'h52, 7'h51, 7'h51, 7'h50, 7'h50, 7'h4f, 7'h4f,
		7'h4e, 7'h4d, 7'h4d, 7'h4d, 7'h4c, 7'h4c, 7'h4b, 7'h4b,
		7'h4a, 7'h4a, 7'h49, 7'h49, 7'h48, 7'h48, 7'h47, 7'h47,
		7'h47, 7'h46, 7'h46, 7'h45, 7'h45, 7'h45, 7'h44, 7'h44,
		7'h43, 7'h43, 7'h43, 7'h42, 7'h42, 7'h42, 7'h41, 7'h41,
		7'h41, 7'h40, 7'h40, 7'h40, 7'h3f, 7'h3f, 7'h3f, 7'h3e,
		7'h3e, 7'h3e, 7'h3d, 7'h3d, 7'h3d, 7'h3c, 7'h3c, 7'h3c,
		7'h3b, 7'h3b, 7'h3b, 7'h3b, 7'h3a, 7'h3a, 7'h3a, 7'h39,
		7'h39, 7'h39, 7'h39, 7'h38, 7'h38, 7'h38, 7'h38, 7'h37,
		7'h37, 7'h37, 7'h37, 7'h36, 7'h36, 7'h36, 7'h36, 7'h35,
		7'h35, 7'h35, 7'h35, 7'h34, 7'h34, 7'h34, 7'h34, 7'h34,
		7'h33, 7'h33, 7'h33, 7'h33, 7'h32, 7'h32, 7'h32, 7'h32,
		7'h32, 7'h31, 7'h31, 7'h31, 7'h31, 7'h31, 7'h30, 7'h30,
		7'h30, 7'h30, 7'h30, 7'h2f, 7'h2f, 7'h2f, 7'h2f, 7'h2f
	};

	localparam logic [31:0] HZ_SCALE  = 32'd11185;
	localparam logic [31:0] LEAD_BIAS = 32'd15;
	localparam int          N_RANDOM  = 1750;
	localparam int          N_DRAIN   = 10;

	// One row of the directed table. Where has_pitch is set, pitch is the
	// value read straight off the definition; otherwise the predictor decides.
	typedef struct packed {
		logic [RATE_W-1:0]  rate;
		logic               has_pitch;
		logic [PITCH_W-1:0] pitch;
	} rate_row_t;

	// One outstanding pitch word together with the rate that caused it.
	typedef struct packed {
		logic [RATE_W-1:0]  rate;
		logic [PITCH_W-1:0] pitch;
	} pitch_due_t;

	// Directed rates: zero, the smallest rates (for 1 and 2 the leading one sits
	// below bit 15 and the characteristic wraps negative), the full-scale rate,
	// the usual audio rates, single bits and alternating patterns.
	localparam int N_ROWS = 22;
	localparam rate_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{18'd0,       1'b1, 32'h0000_0000},
		'{18'd1,       1'b1, 32'hFFE7_3053},
		'{18'h3FFFF,   1'b1, 32'h0107_300F},
		'{18'd2,       1'b0, 32'h0},
		'{18'd3,       1'b0, 32'h0},
		'{18'd4,       1'b0, 32'h0},
		'{18'd5,       1'b0, 32'h0},
		'{18'd8000,    1'b0, 32'h0},
		'{18'd11025,   1'b0, 32'h0},
		'{18'd22050,   1'b0, 32'h0},
		'{18'd32000,   1'b0, 32'h0},
		'{18'd44100,   1'b0, 32'h0},
		'{18'd48000,   1'b0, 32'h0},
		'{18'd96000,   1'b0, 32'h0},
		'{18'd192000,  1'b0, 32'h0},
		'{18'h20000,   1'b0, 32'h0},
		'{18'h1FFFF,   1'b0, 32'h0},
		'{18'h3FFFE,   1'b0, 32'h0},
		'{18'h15555,   1'b0, 32'h0},
		'{18'h2AAAA,   1'b0, 32'h0},
		'{18'h00FFF,   1'b0, 32'h0},
		'{18'h0F000,   1'b0, 32'h0}
	};

	localparam int N_AUDIO = 11;
	localparam logic [RATE_W-1:0] AUDIO_RATES [N_AUDIO] = '{
		18'd8000, 18'd11025, 18'd16000, 18'd22050, 18'd32000, 18'd44100,
		18'd48000, 18'd88200, 18'd96000, 18'd176400, 18'd192000
	};

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               start       = 1'b0;
	logic [RATE_W-1:0]  sample_rate = '0;
	logic               busy;
	logic               done;
	logic [PITCH_W-1:0] pitch_word;

	// Side channel that travels with each beat, so the monitor knows whether
	// the current rate carries a hand-typed pitch.
	logic               row_has_pitch = 1'b0;
	logic [PITCH_W-1:0] row_pitch     = '0;

	pitch_due_t pending_pitch [$];
	pitch_due_t oldest_due;
	int         mismatch_count = 0;
	int         burst_left     = 0;

	sample_rate_to_log_pitch_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.sample_rate(sample_rate),
		.done       (done),
		.pitch_word (pitch_word)
	);

	always #1 clk = ~clk;

	// Predicted pitch word for one rate. The rate is scaled, the leading one
	// of the product gives the characteristic, the seven bits under it pick a
	// segment and the next seven bits interpolate along that segment. Every
	// sum is taken at 32 bits, so small rates wrap the characteristic.
	function automatic logic [PITCH_W-1:0] log_pitch(input logic [RATE_W-1:0] rate);
		logic [31:0] scaled;
		logic [31:0] aligned;
		logic [31:0] characteristic;
		logic [6:0]  seg;
		logic [6:0]  step;
		int          lead;
		if (rate == '0)
			return '0;
		scaled = 32'(rate) * HZ_SCALE;
		lead = 31;
		while (lead > 0 && !scaled[lead])
			lead--;
		aligned = scaled << (31 - lead);
		seg = aligned[30:24];
		step = aligned[23:17];
		characteristic = (32'(lead) - LEAD_BIAS) << 20;
		return characteristic + 32'(SEG_BASE[seg]) + 32'(step) * 32'(SEG_SLOPE[seg]);
	endfunction

	// Random rate, weighted toward the corners of the conversion: the tiny
	// rates (some send the characteristic negative), powers of two and the values
	// just below them (leading-one boundaries), common audio rates, and the odd
	// zero. The rest is uniform over the full 18-bit range.
	function automatic logic [RATE_W-1:0] pick_rate();
		int unsigned shift;
		case ($urandom_range(0, 9))
			0: begin
				return RATE_W'($urandom_range(1, 5));
			end
			1: begin
				shift = $urandom_range(0, RATE_W - 1);
				return ($urandom_range(0, 1) != 0) ? RATE_W'(1) << shift
					: (RATE_W'(1) << shift) - RATE_W'($urandom_range(0, 1));
			end
			2: begin
				return AUDIO_RATES[$urandom_range(0, N_AUDIO - 1)];
			end
			3: begin
				return ($urandom_range(0, 3) == 0) ? '0 : RATE_W'($urandom);
			end
			default: begin
				return RATE_W'($urandom_range(0, (1 << RATE_W) - 1));
			end
		endcase
	endfunction

	// Present one rate and hold it until a beat is taken. The sender works in
	// bursts; at the start of each burst it may first idle for a gap. start
	// is only lowered during such a gap, so a back-to-back beat never sees
	// start dropped and raised in the same step.
	task automatic feed_rate(input logic [RATE_W-1:0] rate, input logic has_pitch,
			input logic [PITCH_W-1:0] pitch);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// Now and then a long burst, so the pipeline runs full for a while.
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 40);
		end
		burst_left--;
		start         <= 1'b1;
		sample_rate   <= rate;
		row_has_pitch <= has_pitch;
		row_pitch     <= pitch;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	// Stop sending and wait until every pitch word in flight has come out.
	task automatic drain_pipeline();
		start <= 1'b0;
		@(posedge clk);
		while (pending_pitch.size() != 0)
			@(posedge clk);
	endtask

	// Monitor. At each rising edge a beat is recorded first and a result is
	// checked after it, so the order of processes within the step does not
	// matter. All values read here are those from before the edge.
	always @(posedge clk) begin
		if (arst_n && start && busy === 1'b0)
			pending_pitch.push_back('{sample_rate,
				row_has_pitch ? row_pitch : log_pitch(sample_rate)});
		if (done === 1'b1) begin
			if (pending_pitch.size() == 0) begin
				$error("pitch_word: expected none, actual %h", pitch_word);
				mismatch_count++;
			end else begin
				oldest_due = pending_pitch.pop_front();
				if (pitch_word !== oldest_due.pitch) begin
					$error("pitch_word: expected %h, actual %h (sample_rate %0d)",
						oldest_due.pitch, pitch_word, oldest_due.rate);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: walk the table in order.
		for (int r = 0; r < N_ROWS; r++)
			feed_rate(DIRECTED_ROWS[r].rate, DIRECTED_ROWS[r].has_pitch,
				DIRECTED_ROWS[r].pitch);

		// Let the pipeline empty out once before the random traffic starts.
		drain_pipeline();
		burst_left = 0;

		// Random part, with an occasional full drain in between.
		for (int n = 0; n < N_RANDOM; n++) begin
			feed_rate(pick_rate(), 1'b0, '0);
			if ($urandom_range(0, 299) == 0) begin
				drain_pipeline();
				burst_left = 0;
			end
		end

		drain_pipeline();
		// Give any stray result a chance to appear before the verdict.
		repeat (N_DRAIN) @(posedge clk);

		if (pending_pitch.size() != 0) begin
			$error("pitch_word: %0d expected beats never came out", pending_pitch.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("sample_rate_to_log_pitch_core: match");
		else
			$display("sample_rate_to_log_pitch_core: mismatch");
		$finish;
	end

	// Watchdog: a correct run needs well under a tenth of this time.
	initial begin
		#1000000;
		$display("sample_rate_to_log_pitch_core: mismatch");
		$finish;
	end

endmodule
